// ===== hw/rtl/euv_pkg.sv =====
// ============================================================================
// euv_pkg: shared definitions for the extended UTF-8 stream validator
// Holds the classified word format, the lead length codes and the value
// limits used to reject overlong and out-of-range sequences.
// ============================================================================
package euv_pkg;

    // Default width of the running character and UTF-16 unit counters.
    localparam int COUNT_WIDTH_DEF = 16;

    // Width of the count fields on the result channel.
    localparam int OUT_COUNT_W = 16;

    // Depth of the queue between the classifier and the sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Width of the code point accumulator (four 6-bit continuation groups).
    localparam int ACC_W = 24;

    // Sequence length codes taken from the lead byte.
    typedef logic [2:0] t_len;
    localparam t_len LEN_BAD = 3'd0;
    localparam t_len LEN_1   = 3'd1;
    localparam t_len LEN_2   = 3'd2;
    localparam t_len LEN_3   = 3'd3;
    localparam t_len LEN_4   = 3'd4;
    localparam t_len LEN_5   = 3'd5;

    // Smallest legal values for three, four and five byte forms, and the
    // largest legal five byte value.
    localparam logic [ACC_W-1:0] MIN_VAL_3 = 24'h000800;
    localparam logic [ACC_W-1:0] MIN_VAL_4 = 24'h010000;
    localparam logic [ACC_W-1:0] MIN_VAL_5 = 24'h200000;
    localparam logic [ACC_W-1:0] MAX_VAL_5 = 24'h3fff7f;

    // One input byte after classification.
    typedef struct packed {
        logic       last;       // final byte of the string
        t_len       lead_len;   // length if taken as a lead byte
        logic [4:0] lead_bits;  // lead payload, already masked
        logic       cont_ok;    // byte has the 10xxxxxx form
        logic [5:0] cont_bits;  // continuation payload
    } t_item;

endpackage

// ===== hw/rtl/euv_in_if.sv =====
// ============================================================================
// euv_in_if: byte channel into the validator
// Valid/ready channel carrying one string byte and its end marker.
// ============================================================================
interface euv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/euv_out_if.sv =====
// ============================================================================
// euv_out_if: result channel out of the validator
// Valid/ready channel carrying the verdict and both counts of one string.
// ============================================================================
interface euv_out_if;
    logic        valid;
    logic        ready;
    logic        is_valid;
    logic [15:0] char_count;
    logic [15:0] utf16_count;

    modport source (output valid, output is_valid, output char_count, output utf16_count,
                    input ready);
    modport sink   (input valid, input is_valid, input char_count, input utf16_count,
                    output ready);
endinterface

// ===== hw/rtl/euv_front.sv =====
// ============================================================================
// euv_front: byte classifier
// Accepts input words while the queue has room and decodes each byte into
// its lead length, masked lead payload and continuation payload.
// ============================================================================
module euv_front (
    euv_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output euv_pkg::t_item  o_item
);

    logic [7:0] w_b;

    assign w_b         = i_in.data_byte;
    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;

    // Decode the byte both as a lead and as a continuation.
    always_comb begin
        o_item.last      = i_in.last_byte;
        o_item.cont_ok   = (w_b[7:6] == 2'b10);
        o_item.cont_bits = w_b[5:0];
        o_item.lead_bits = 5'd0;
        if (w_b inside {[8'h00:8'h7f]}) begin
            o_item.lead_len = euv_pkg::LEN_1;
        end else if (w_b inside {[8'hc0:8'hdf]}) begin
            o_item.lead_len  = euv_pkg::LEN_2;
            o_item.lead_bits = w_b[4:0];
        end else if (w_b inside {[8'he0:8'hef]}) begin
            o_item.lead_len  = euv_pkg::LEN_3;
            o_item.lead_bits = {1'b0, w_b[3:0]};
        end else if (w_b inside {[8'hf0:8'hf7]}) begin
            o_item.lead_len  = euv_pkg::LEN_4;
            o_item.lead_bits = {2'b00, w_b[2:0]};
        end else if (w_b == 8'hf8) begin
            o_item.lead_len = euv_pkg::LEN_5;
        end else begin
            o_item.lead_len = euv_pkg::LEN_BAD;
        end
    end

endmodule

// ===== hw/rtl/euv_fifo.sv =====
// ============================================================================
// euv_fifo: classified word queue
// Small register queue that decouples the classifier from the sequencer.
// ============================================================================
module euv_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  euv_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output euv_pkg::t_item  o_item
);

    euv_pkg::t_item                   r_mem [euv_pkg::QUEUE_DEPTH];
    logic [euv_pkg::QUEUE_PTR_W-1:0]  r_wptr;
    logic [euv_pkg::QUEUE_PTR_W-1:0]  r_rptr;
    logic [euv_pkg::QUEUE_PTR_W:0]    r_count;

    assign o_full  = (r_count == (euv_pkg::QUEUE_PTR_W+1)'(euv_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    // Storage is written at the tail; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/euv_back.sv =====
// ============================================================================
// euv_back: sequence tracker and result register
// Walks the classified bytes through each sequence, checks continuation
// form and value range, keeps the saturating counts and holds the result.
// ============================================================================
module euv_back #(
    parameter int COUNT_WIDTH = euv_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  euv_pkg::t_item  i_item,
    output logic            o_pop,
    euv_out_if.source       o_out
);

    logic [2:0]                r_rem,   n_rem;
    euv_pkg::t_len             r_seq,   n_seq;
    logic [euv_pkg::ACC_W-1:0] r_acc,   n_acc;
    logic                      r_ok,    n_ok;
    logic                      r_stop,  n_stop;
    logic [COUNT_WIDTH-1:0]    r_chars, n_chars;
    logic [COUNT_WIDTH-1:0]    r_units, n_units;

    logic                      r_out_valid;
    logic                      r_out_ok;
    logic [euv_pkg::OUT_COUNT_W-1:0] r_out_chars;
    logic [euv_pkg::OUT_COUNT_W-1:0] r_out_units;

    logic                      w_count;
    logic                      w_two;
    logic [COUNT_WIDTH:0]      w_sum_c;
    logic [COUNT_WIDTH:0]      w_sum_u;

    // A word moves on unless it would produce a result that cannot be held.
    assign o_pop = i_valid && (!i_item.last || !r_out_valid || o_out.ready);

    assign o_out.valid       = r_out_valid;
    assign o_out.is_valid    = r_out_ok;
    assign o_out.char_count  = r_out_chars;
    assign o_out.utf16_count = r_out_units;

    // Sequence tracking for the word at the head of the queue.
    always_comb begin
        n_rem   = r_rem;
        n_seq   = r_seq;
        n_acc   = r_acc;
        n_ok    = r_ok;
        n_stop  = r_stop;
        w_count = 1'b0;
        w_two   = 1'b0;
        if (r_rem == 3'd0) begin
            case (i_item.lead_len)
                euv_pkg::LEN_BAD: begin
                    n_ok   = 1'b0;
                    n_stop = 1'b1;
                end
                euv_pkg::LEN_1: begin
                    w_count = 1'b1;
                end
                default: begin
                    n_seq = i_item.lead_len;
                    n_rem = i_item.lead_len - 3'd1;
                    n_acc = euv_pkg::ACC_W'(i_item.lead_bits);
                end
            endcase
        end else begin
            if (!i_item.cont_ok) begin
                n_ok = 1'b0;
            end
            n_acc = {r_acc[euv_pkg::ACC_W-7:0], i_item.cont_bits};
            n_rem = r_rem - 3'd1;
            if (r_rem == 3'd1) begin
                // Sequence complete: reject overlong and out-of-range values.
                if ((r_seq == euv_pkg::LEN_3 && n_acc < euv_pkg::MIN_VAL_3) ||
                    (r_seq == euv_pkg::LEN_4 && n_acc < euv_pkg::MIN_VAL_4) ||
                    (r_seq == euv_pkg::LEN_5 &&
                     (n_acc < euv_pkg::MIN_VAL_5 || n_acc > euv_pkg::MAX_VAL_5))) begin
                    n_ok = 1'b0;
                end
                w_count = 1'b1;
                w_two   = (r_seq >= euv_pkg::LEN_4);
                n_seq   = '0;
                n_acc   = '0;
            end
        end
    end

    // Saturating counters, frozen once counting has stopped.
    always_comb begin
        w_sum_c = {1'b0, r_chars} + (COUNT_WIDTH+1)'(1);
        w_sum_u = {1'b0, r_units} + (w_two ? (COUNT_WIDTH+1)'(2) : (COUNT_WIDTH+1)'(1));
        n_chars = r_chars;
        n_units = r_units;
        if (w_count && !r_stop) begin
            n_chars = w_sum_c[COUNT_WIDTH] ? '1 : w_sum_c[COUNT_WIDTH-1:0];
            n_units = w_sum_u[COUNT_WIDTH] ? '1 : w_sum_u[COUNT_WIDTH-1:0];
        end
    end

    // State update; the last byte reports and returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_seq       <= '0;
            r_acc       <= '0;
            r_ok        <= 1'b1;
            r_stop      <= 1'b0;
            r_chars     <= '0;
            r_units     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the register; otherwise a taken one leaves it.
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_item.last) begin
                    r_out_ok    <= n_ok && (n_rem == 3'd0);
                    r_out_chars <= euv_pkg::OUT_COUNT_W'(n_chars);
                    r_out_units <= euv_pkg::OUT_COUNT_W'(n_units);
                    r_rem       <= '0;
                    r_seq       <= '0;
                    r_acc       <= '0;
                    r_ok        <= 1'b1;
                    r_stop      <= 1'b0;
                    r_chars     <= '0;
                    r_units     <= '0;
                end else begin
                    r_rem   <= n_rem;
                    r_seq   <= n_seq;
                    r_acc   <= n_acc;
                    r_ok    <= n_ok;
                    r_stop  <= n_stop;
                    r_chars <= n_chars;
                    r_units <= n_units;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/extended_utf8_stream_validator.sv =====
// ============================================================================
// extended_utf8_stream_validator: streaming extended UTF-8 checker
// Checks strings byte by byte and reports validity and character counts.
// ============================================================================
// Usage:
//   i_in carries one string byte per word, with last_byte set on the final
//   byte. o_out carries one word per string: is_valid, char_count and
//   utf16_count (low 16 bits of saturating counters of COUNT_WIDTH bits).
//   Throughput is one byte per cycle while the queue has room. The
//   classifier takes a byte into a four-entry queue; the sequencer takes
//   one word per cycle unless a last byte waits on a held result. Results
//   come through the queue and output register, after words queued ahead.
//   The result sits in an output register, so bytes of the next string keep
//   flowing while it waits; only a second last byte stalls until the first
//   result is taken, and meanwhile the queue fills and i_in.ready drops.
//   Reset (i_rst_n low, synchronous) empties the queue, drops any result
//   and returns the sequence state and counters to their initial values.
//   The block clears its sequence state and counters as it takes a last byte.
// ============================================================================
module extended_utf8_stream_validator #(
    parameter int COUNT_WIDTH = euv_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    euv_in_if.sink     i_in,
    euv_out_if.source  o_out
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_q_valid;
    euv_pkg::t_item w_f_item;
    euv_pkg::t_item w_q_item;

    // Front: accept and classify.
    euv_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_f_item)
    );

    // Queue between the two halves.
    euv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Back: track sequences and deliver results.
    euv_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    // A result only appears after the last byte of a string left the queue.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_pop && w_q_item.last))
        else $error("result raised without a last byte");

    // Taking a last byte from the queue always presents a result next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_q_item.last |=> o_out.valid)
        else $error("last byte consumed but no result presented");

    // Reset leaves no result pending and the queue empty.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !w_q_valid)
        else $error("state not cleared by reset");
`endif

endmodule

// ===== verif/tb_extended_utf8_stream_validator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_extended_utf8_stream_validator: self-checking bench for the validator
// Streams strings into the byte channel with random idling on both sides.
// A behavioral predictor works out each string's verdict and counts, and
// every result word is checked against the oldest expected verdict.
// ============================================================================
module tb_extended_utf8_stream_validator;

    localparam int CNT_W        = euv_pkg::COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_WAIT   = 24;
    localparam int RANDOM_BYTES = 1050;
    localparam int STEADY_BYTES = 130;

    // Expected verdict of one string, as it appears on the result channel.
    typedef struct packed {
        logic                            ok;
        logic [euv_pkg::OUT_COUNT_W-1:0] chars;
        logic [euv_pkg::OUT_COUNT_W-1:0] units;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    euv_in_if  in_ch ();
    euv_out_if out_ch ();

    extended_utf8_stream_validator #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Predictor state for the string in progress.
    logic [2:0]                pend_bytes;
    euv_pkg::t_len             open_len;
    logic [euv_pkg::ACC_W-1:0] code_acc;
    logic                      str_ok;
    logic                      count_halted;
    logic [CNT_W-1:0]          char_tally;
    logic [CNT_W-1:0]          unit_tally;

    t_verdict   pending_verdicts[$];
    logic [7:0] str_bytes[$];

    int  error_count;
    int  cycle_count;
    int  bytes_sent;
    bit  idle_on;
    bit  stall_on;
    int  hold_request;
    int  hold_left;
    int  stall_left;

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void clear_string_state();
        pend_bytes   = 3'd0;
        open_len     = euv_pkg::LEN_BAD;
        code_acc     = '0;
        str_ok       = 1'b1;
        count_halted = 1'b0;
        char_tally   = '0;
        unit_tally   = '0;
    endfunction

    function automatic euv_pkg::t_len lead_class(input logic [7:0] b);
        if (!b[7])                 return euv_pkg::LEN_1;
        if (b[7:5] == 3'b110)      return euv_pkg::LEN_2;
        if (b[7:4] == 4'b1110)     return euv_pkg::LEN_3;
        if (b[7:3] == 5'b11110)    return euv_pkg::LEN_4;
        if (b == 8'hF8)            return euv_pkg::LEN_5;
        return euv_pkg::LEN_BAD;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input int unsigned k);
        logic [CNT_W:0] s;
        s = {1'b0, v} + (CNT_W+1)'(k);
        if (s[CNT_W]) return '1;
        return s[CNT_W-1:0];
    endfunction

    // Counting stops for the rest of the string once a bad lead byte has been seen.
    function automatic void tally_sequence(input euv_pkg::t_len len);
        if (count_halted) return;
        char_tally = sat_add(char_tally, 1);
        unit_tally = sat_add(unit_tally, (len >= euv_pkg::LEN_4) ? 2 : 1);
    endfunction

    // Folds one accepted word into the string state; the last byte of a
    // string produces its expected verdict.
    function automatic void absorb_byte(input logic [7:0] b, input logic is_last);
        euv_pkg::t_len len;
        t_verdict      v;
        if (pend_bytes == 3'd0) begin
            len = lead_class(b);
            if (len == euv_pkg::LEN_BAD) begin
                str_ok       = 1'b0;
                count_halted = 1'b1;
            end else if (len == euv_pkg::LEN_1) begin
                tally_sequence(euv_pkg::LEN_1);
            end else begin
                open_len   = len;
                pend_bytes = len - 3'd1;
                case (len)
                    euv_pkg::LEN_2: code_acc = euv_pkg::ACC_W'(b[4:0]);
                    euv_pkg::LEN_3: code_acc = euv_pkg::ACC_W'(b[3:0]);
                    euv_pkg::LEN_4: code_acc = euv_pkg::ACC_W'(b[2:0]);
                    default:        code_acc = '0;
                endcase
            end
        end else begin
            if (b[7:6] != 2'b10) str_ok = 1'b0;
            code_acc   = {code_acc[euv_pkg::ACC_W-7:0], b[5:0]};
            pend_bytes = pend_bytes - 3'd1;
            if (pend_bytes == 3'd0) begin
                if ((open_len == euv_pkg::LEN_3 && code_acc < euv_pkg::MIN_VAL_3) ||
                    (open_len == euv_pkg::LEN_4 && code_acc < euv_pkg::MIN_VAL_4) ||
                    (open_len == euv_pkg::LEN_5 &&
                     (code_acc < euv_pkg::MIN_VAL_5 || code_acc > euv_pkg::MAX_VAL_5)))
                    str_ok = 1'b0;
                tally_sequence(open_len);
                open_len = euv_pkg::LEN_BAD;
                code_acc = '0;
            end
        end

        if (is_last) begin
            if (pend_bytes != 3'd0) str_ok = 1'b0;
            v.ok    = str_ok;
            v.chars = char_tally[euv_pkg::OUT_COUNT_W-1:0];
            v.units = unit_tally[euv_pkg::OUT_COUNT_W-1:0];
            pending_verdicts.push_back(v);
            clear_string_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, checking
    // ------------------------------------------------------------------------

    function automatic void check_verdict();
        t_verdict want;
        if (pending_verdicts.size() == 0) begin
            $error("result word with no string pending: is_valid %0d chars %0d units %0d",
                   out_ch.is_valid, out_ch.char_count, out_ch.utf16_count);
            error_count++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (out_ch.is_valid !== want.ok) begin
            $error("is_valid: expected %0d, got %0d", want.ok, out_ch.is_valid);
            error_count++;
        end
        if (out_ch.char_count !== want.chars) begin
            $error("char_count: expected %0d, got %0d", want.chars, out_ch.char_count);
            error_count++;
        end
        if (out_ch.utf16_count !== want.units) begin
            $error("utf16_count: expected %0d, got %0d", want.units, out_ch.utf16_count);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) check_verdict();
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // Offers one word and waits for it to be taken. Valid stays high on
    // return so that the next word follows without a bubble.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 17);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= is_last;
        do @(posedge i_clk); while (!in_ch.ready);
        absorb_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // Appends one encoded sequence of n bytes carrying value v.
    task automatic put_seq(input int n, input logic [23:0] v);
        case (n)
            1: str_bytes.push_back({1'b0, v[6:0]});
            2: begin
                str_bytes.push_back({3'b110, v[10:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
            3: begin
                str_bytes.push_back({4'b1110, v[15:12]});
                str_bytes.push_back({2'b10, v[11:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
            4: begin
                str_bytes.push_back({5'b11110, v[20:18]});
                str_bytes.push_back({2'b10, v[17:12]});
                str_bytes.push_back({2'b10, v[11:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
            default: begin
                str_bytes.push_back(8'hF8);
                str_bytes.push_back({2'b10, v[23:18]});
                str_bytes.push_back({2'b10, v[17:12]});
                str_bytes.push_back({2'b10, v[11:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
        endcase
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Lone bytes at the ends of the ASCII range and bad lead bytes.
    task automatic test_single_bytes();
        str_bytes = {8'h00};
        send_string();
        str_bytes = {8'h7F, 8'h80};
        send_string();
        str_bytes = {8'hFF};
        send_string();
    endtask

    // C1 lead, a surrogate, the four-byte form of 10FFFF, then two overlong forms.
    task automatic test_lead_forms();
        str_bytes = {8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        str_bytes = {8'hE0, 8'h9F, 8'hBF, 8'hF0, 8'h8F, 8'hBF, 8'hBF};
        send_string();
    endtask

    // Five-byte lead at the lowest legal value and just past the highest.
    task automatic test_five_byte_limits();
        str_bytes = {8'hF8, 8'h88, 8'h80, 8'h80, 8'h80};
        send_string();
        str_bytes = {8'hF8, 8'h8F, 8'hBF, 8'hBE, 8'h80};
        send_string();
    endtask

    // Bad continuation keeps counting; truncation and a bad lead do not.
    task automatic test_broken_strings();
        str_bytes = {8'hC3, 8'h41};
        send_string();
        str_bytes = {8'hE2, 8'h82};
        send_string();
        str_bytes = {8'h41, 8'hF9, 8'h41};
        send_string();
    endtask

    // The result side holds off long enough for the byte queue to fill.
    task automatic test_output_hold();
        idle_on      = 1'b0;
        hold_request = 300;
        for (int s = 0; s < 10; s++) begin
            str_bytes.delete();
            for (int i = 0; i < 3; i++) put_seq(1, 24'($urandom_range(0, 127)));
            send_string();
        end
    endtask

    // Builds one string, mostly well-formed, sometimes damaged.
    task automatic build_random_string();
        int          nseq;
        int          pick;
        int          pos;
        logic [23:0] v;
        str_bytes.delete();
        nseq = $urandom_range(1, 10);
        for (int i = 0; i < nseq; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: put_seq(1, 24'($urandom_range(0, 127)));
                2: put_seq(2, 24'($urandom_range(0, 12'h7FF)));
                3, 4: begin
                    if ($urandom_range(0, 7) == 0) v = 24'($urandom_range(0, 16'hFFFF));
                    else v = 24'($urandom_range(16'h800, 16'hFFFF));
                    put_seq(3, v);
                end
                5, 6: begin
                    if ($urandom_range(0, 7) == 0) v = 24'($urandom_range(0, 24'h1FFFFF));
                    else v = 24'($urandom_range(24'h10000, 24'h1FFFFF));
                    put_seq(4, v);
                end
                7, 8: begin
                    case ($urandom_range(0, 7))
                        0: v = 24'($urandom_range(0, 24'hFFFFFF));
                        1: v = 24'($urandom_range(24'h1FFFF0, 24'h20000F));
                        2: v = 24'($urandom_range(24'h3FFF70, 24'h3FFF8F));
                        default: v = 24'($urandom_range(24'h200000, 24'h3FFF7F));
                    endcase
                    put_seq(5, v);
                end
                default: str_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end

        // Damage: a random byte, a dropped tail byte, or a flipped marker bit.
        if ($urandom_range(0, 5) == 0) begin
            pos = $urandom_range(0, str_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0: str_bytes[pos] = 8'($urandom_range(0, 255));
                1: if (str_bytes.size() > 1) void'(str_bytes.pop_back());
                default: str_bytes[pos][6] = ~str_bytes[pos][6];
            endcase
        end
    endtask

    // Random strings in segments, each with its own idling mix.
    task automatic test_random_strings();
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            idle_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            for (int s = 0; s < 20 && bytes_sent - start_count < RANDOM_BYTES; s++) begin
                build_random_string();
                send_string();
            end
        end
    endtask

    // Closing stretch of random strings with no idling on either side.
    task automatic test_steady_stream();
        int start_count;
        idle_on     = 1'b0;
        stall_on    = 1'b0;
        start_count = bytes_sent;
        while (bytes_sent - start_count < STEADY_BYTES) begin
            build_random_string();
            send_string();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= 8'h00;
        in_ch.last_byte  <= 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        bytes_sent   = 0;
        hold_request = 0;
        hold_left    = 0;
        stall_left   = 0;
        idle_on      = 1'b1;
        stall_on     = 1'b1;
        clear_string_state();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_lead_forms();
        test_five_byte_limits();
        test_broken_strings();
        test_output_hold();
        test_random_strings();
        test_steady_stream();

        // Let every outstanding result word come out, then watch for strays.
        stop_sending();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
